// ===== rtl/assert_macros.svh =====
// assertion macros used by the port level checker file
// no dependencies; clock and reset names are given by the caller
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked also while reset is held
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/rgbfs_pkg.sv =====
// shared types, constants and helper functions of the rgb led frame store
// no dependencies
package rgbfs_pkg;

    localparam int LED_COUNT   = 24;
    localparam int RED_SHIFT   = 4;
    localparam int GREEN_SHIFT = 4;
    localparam int BLUE_SHIFT  = 4;
    localparam int TABLE_LEN   = 24;
    localparam int TBL_W       = $clog2(TABLE_LEN);
    localparam int IDX_W       = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
    localparam int COLOUR_W    = 24;
    localparam int BRIGHT_W    = 8;
    localparam logic [IDX_W-1:0] LAST_LED = IDX_W'(LED_COUNT - 1);

    // command codes
    localparam logic [2:0] FN_SET_LED    = 3'd0;
    localparam logic [2:0] FN_SET_SINGLE = 3'd1;
    localparam logic [2:0] FN_FILL       = 3'd2;
    localparam logic [2:0] FN_SET_BRIGHT = 3'd3;
    localparam logic [2:0] FN_UPDATE     = 3'd4;

    typedef logic [6:0] chan_tab_t [TABLE_LEN];

    localparam chan_tab_t CHAN_RED = '{
        7'd68, 7'd70, 7'd9,  7'd27, 7'd6,  7'd44, 7'd20, 7'd54, 7'd65, 7'd52, 7'd31, 7'd63,
        7'd28, 7'd13, 7'd49, 7'd40, 7'd38, 7'd18, 7'd12, 7'd2,  7'd32, 7'd35, 7'd43, 7'd41};
    localparam chan_tab_t CHAN_GREEN = '{
        7'd60, 7'd62, 7'd26, 7'd15, 7'd7,  7'd42, 7'd10, 7'd59, 7'd51, 7'd56, 7'd1,  7'd64,
        7'd34, 7'd53, 7'd47, 7'd61, 7'd45, 7'd22, 7'd23, 7'd30, 7'd25, 7'd67, 7'd29, 7'd21};
    localparam chan_tab_t CHAN_BLUE = '{
        7'd71, 7'd69, 7'd8,  7'd11, 7'd4,  7'd14, 7'd17, 7'd57, 7'd66, 7'd58, 7'd46, 7'd33,
        7'd3,  7'd50, 7'd55, 7'd36, 7'd48, 7'd37, 7'd16, 7'd5,  7'd24, 7'd39, 7'd0,  7'd19};

    typedef struct packed {
        logic [2:0] func;
        logic [7:0] led_index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       override_brightness;
        logic [7:0] brightness;
    } in_beat_t;

    typedef struct packed {
        logic [4:0]  led_number;
        logic [6:0]  red_channel;
        logic [11:0] red_value;
        logic [6:0]  green_channel;
        logic [11:0] green_value;
        logic [6:0]  blue_channel;
        logic [11:0] blue_value;
        logic [7:0]  white_out;
        logic        last;
    } out_beat_t;

    // controller to datapath
    typedef struct packed {
        logic             capture;
        logic             col_we;
        logic             br_we;
        logic             col_zero;
        logic             use_idx;
        logic             load;
        logic [IDX_W-1:0] addr;
        logic [IDX_W-1:0] raddr;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic hit;
        logic idx_ok;
        logic ovr;
    } dp_sts_t;

    // channel number of an led, zero beyond the table
    function automatic logic [6:0] chan_lookup(input logic [IDX_W-1:0] idx,
                                               input chan_tab_t tab);
        logic [7:0] wide;
        logic [6:0] r;
        wide = 8'(idx);
        r    = '0;
        if (wide < 8'(TABLE_LEN)) begin
            r = tab[wide[TBL_W-1:0]];
        end
        return r;
    endfunction

    // brightness times component, shifted and clipped to 12 bits
    function automatic logic [11:0] scale_comp(input logic [7:0] b, input logic [7:0] c,
                                               input int sh);
        logic [15:0] p;
        logic [15:0] s;
        p = b * c;
        s = p >> sh;
        return (s > 16'd4095) ? 12'hFFF : s[11:0];
    endfunction

endpackage

// ===== rtl/rgbfs_ram.sv =====
// generic single write port ram with registered read
// no dependencies
module rgbfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 24
) (
    input  logic                                     aclk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// ===== rtl/rgbfs_ctrl.sv =====
// controller state machine: command decode, store sweeps, update sequencing
// depends on rgbfs_pkg
module rgbfs_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [2:0]          s_func,
    output logic                m_valid,
    input  logic                m_ready,
    input  rgbfs_pkg::dp_sts_t  sts,
    output rgbfs_pkg::dp_cmd_t  cmd
);
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_ONE   = 2'd1;
    localparam logic [1:0] ST_SWEEP = 2'd2;
    localparam logic [1:0] ST_UPD   = 2'd3;

    logic [1:0]                  state_reg, state_next;
    logic [2:0]                  func_reg, func_next;
    logic [rgbfs_pkg::IDX_W-1:0] cnt_reg, cnt_next;
    logic                        mvalid_reg, mvalid_next;
    logic                        accept;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;
    assign m_valid = mvalid_reg;

    always_comb begin
        state_next = state_reg;
        func_next  = func_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.addr   = cnt_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    func_next   = s_func;
                    cmd.capture = 1'b1;
                    case (s_func)
                        rgbfs_pkg::FN_SET_LED: begin
                            state_next = ST_ONE;
                        end
                        rgbfs_pkg::FN_SET_SINGLE, rgbfs_pkg::FN_FILL,
                        rgbfs_pkg::FN_SET_BRIGHT: begin
                            cnt_next   = '0;
                            state_next = ST_SWEEP;
                        end
                        rgbfs_pkg::FN_UPDATE: begin
                            cnt_next   = '0;
                            state_next = ST_UPD;
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_ONE: begin
                cmd.use_idx = 1'b1;
                cmd.col_we  = sts.idx_ok;
                cmd.br_we   = sts.idx_ok && sts.ovr;
                state_next  = ST_IDLE;
            end
            ST_SWEEP: begin
                case (func_reg)
                    rgbfs_pkg::FN_SET_SINGLE: begin
                        cmd.col_we   = 1'b1;
                        cmd.col_zero = !sts.hit;
                        cmd.br_we    = sts.hit && sts.ovr;
                    end
                    rgbfs_pkg::FN_FILL: begin
                        cmd.col_we = 1'b1;
                    end
                    rgbfs_pkg::FN_SET_BRIGHT: begin
                        cmd.br_we = 1'b1;
                    end
                    default: begin
                        cmd.col_we = 1'b0;
                    end
                endcase
                if (cnt_reg == rgbfs_pkg::LAST_LED) begin
                    state_next = ST_IDLE;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_UPD: begin
                if (!mvalid_reg || m_ready) begin
                    cmd.load = 1'b1;
                    if (cnt_reg == rgbfs_pkg::LAST_LED) begin
                        state_next = ST_IDLE;
                    end else begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        // read address runs one step ahead of the output register
        cmd.raddr = cnt_next;
    end

    assign mvalid_next = cmd.load ? 1'b1 : (m_ready ? 1'b0 : mvalid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            func_reg   <= rgbfs_pkg::FN_SET_LED;
            cnt_reg    <= '0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            func_reg   <= func_next;
            cnt_reg    <= cnt_next;
            mvalid_reg <= mvalid_next;
        end
    end
endmodule

// ===== rtl/rgbfs_dp.sv =====
// datapath: command registers, colour and brightness rams, scaling and output register
// depends on rgbfs_pkg and rgbfs_ram
module rgbfs_dp (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  rgbfs_pkg::dp_cmd_t   cmd,
    input  rgbfs_pkg::in_beat_t  s_data,
    input  logic                 cfg_wr_en,
    input  logic [7:0]           cfg_wr_data,
    output rgbfs_pkg::dp_sts_t   sts,
    output rgbfs_pkg::out_beat_t m_data
);
    logic [rgbfs_pkg::COLOUR_W-1:0]  col_reg;
    logic [rgbfs_pkg::BRIGHT_W-1:0]  br_reg;
    logic [7:0]                      idx_reg;
    logic                            ovr_reg;
    logic [7:0]                      white_reg;
    logic [rgbfs_pkg::LED_COUNT-1:0] col_vld_reg, col_vld_next;
    logic [rgbfs_pkg::LED_COUNT-1:0] br_vld_reg, br_vld_next;
    logic                            rd_cvld_reg, rd_bvld_reg;
    rgbfs_pkg::out_beat_t            out_reg;

    logic [rgbfs_pkg::IDX_W-1:0]     waddr;
    logic [rgbfs_pkg::COLOUR_W-1:0]  col_wdata, col_rd, col_eff;
    logic [rgbfs_pkg::BRIGHT_W-1:0]  br_rd, br_eff;

    assign waddr     = cmd.use_idx ? idx_reg[rgbfs_pkg::IDX_W-1:0] : cmd.addr;
    assign col_wdata = cmd.col_zero ? '0 : col_reg;

    assign sts.idx_ok = idx_reg < 8'(rgbfs_pkg::LED_COUNT);
    assign sts.hit    = idx_reg == 8'(cmd.addr);
    assign sts.ovr    = ovr_reg;

    rgbfs_ram #(.WIDTH(rgbfs_pkg::COLOUR_W), .DEPTH(rgbfs_pkg::LED_COUNT)) u_col_ram (
        .aclk  (aclk),
        .we    (cmd.col_we),
        .waddr (waddr),
        .wdata (col_wdata),
        .raddr (cmd.raddr),
        .rdata (col_rd)
    );

    rgbfs_ram #(.WIDTH(rgbfs_pkg::BRIGHT_W), .DEPTH(rgbfs_pkg::LED_COUNT)) u_br_ram (
        .aclk  (aclk),
        .we    (cmd.br_we),
        .waddr (waddr),
        .wdata (br_reg),
        .raddr (cmd.raddr),
        .rdata (br_rd)
    );

    // entries never written since reset read as black / zero
    assign col_vld_next = col_vld_reg
                        | (cmd.col_we ? (rgbfs_pkg::LED_COUNT'(1) << waddr) : '0);
    assign br_vld_next  = br_vld_reg
                        | (cmd.br_we ? (rgbfs_pkg::LED_COUNT'(1) << waddr) : '0);
    assign col_eff = rd_cvld_reg ? col_rd : '0;
    assign br_eff  = rd_bvld_reg ? br_rd : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_vld_reg <= '0;
            br_vld_reg  <= '0;
            white_reg   <= '0;
        end else begin
            col_vld_reg <= col_vld_next;
            br_vld_reg  <= br_vld_next;
            if (cfg_wr_en) begin
                white_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rd_cvld_reg <= col_vld_reg[cmd.raddr];
        rd_bvld_reg <= br_vld_reg[cmd.raddr];
        if (cmd.capture) begin
            col_reg <= {s_data.red, s_data.green, s_data.blue};
            br_reg  <= s_data.brightness;
            idx_reg <= s_data.led_index;
            ovr_reg <= s_data.override_brightness;
        end
        if (cmd.load) begin
            out_reg.led_number    <= 5'(cmd.addr);
            out_reg.red_channel   <= rgbfs_pkg::chan_lookup(cmd.addr, rgbfs_pkg::CHAN_RED);
            out_reg.green_channel <= rgbfs_pkg::chan_lookup(cmd.addr, rgbfs_pkg::CHAN_GREEN);
            out_reg.blue_channel  <= rgbfs_pkg::chan_lookup(cmd.addr, rgbfs_pkg::CHAN_BLUE);
            out_reg.red_value     <= rgbfs_pkg::scale_comp(br_eff, col_eff[23:16],
                                                           rgbfs_pkg::RED_SHIFT);
            out_reg.green_value   <= rgbfs_pkg::scale_comp(br_eff, col_eff[15:8],
                                                           rgbfs_pkg::GREEN_SHIFT);
            out_reg.blue_value    <= rgbfs_pkg::scale_comp(br_eff, col_eff[7:0],
                                                           rgbfs_pkg::BLUE_SHIFT);
            out_reg.white_out     <= white_reg;
            out_reg.last          <= (cmd.addr == rgbfs_pkg::LAST_LED);
        end
    end

    assign m_data = out_reg;
endmodule

// ===== rtl/rgb_led_frame_store_scaler_top.sv =====
// Frame store for LED_COUNT rgb leds with per-led brightness. Commands arrive as one
// beat each on s_*: set one led (an index at or beyond LED_COUNT is dropped), set a
// single led and blank the rest, fill all colours, set all brightness (each a sweep
// over all LED_COUNT leds, one ram entry per cycle through the single write port).
// An update emits LED_COUNT result beats on m_*, in led order, each carrying the
// three scaled drive levels (brightness * component >> shift, clipped to 4095), the
// fixed driver channel numbers and the white lamp level; last marks the final led.
// With m_ready held high an update gives one beat per cycle, paced by the registered
// ram read that runs one led ahead of the output register. A new command is taken as
// soon as the previous one has left the controller, even while the final result beat
// still waits in the output register. The stores read as zero after reset through
// per-entry valid bits, so there is no clearing pass. The user writes white_level
// through cfg_wr_en / cfg_wr_data only while the block is idle; it is not enforced.
// depends on rgbfs_pkg, rgbfs_ctrl, rgbfs_dp
module rgb_led_frame_store_scaler_top (
    input  logic                 aclk,
    input  logic                 aresetn,
    // command channel
    input  logic                 s_valid,
    output logic                 s_ready,
    input  rgbfs_pkg::in_beat_t  s_data,
    // result channel
    output logic                 m_valid,
    input  logic                 m_ready,
    output rgbfs_pkg::out_beat_t m_data,
    // white level register
    input  logic                 cfg_wr_en,
    input  logic [7:0]           cfg_wr_data
);
    rgbfs_pkg::dp_cmd_t cmd;
    rgbfs_pkg::dp_sts_t sts;

    // sequencing: command decode, sweep counter, output valid
    rgbfs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_func  (s_data.func),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // stores, scaling multipliers and the result register
    rgbfs_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .s_data      (s_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .sts         (sts),
        .m_data      (m_data)
    );
endmodule

// ===== rtl/rgbfs_checker.sv =====
// port level checks of the frame store, bound to the top level
// depends on rgbfs_pkg and assert_macros.svh
`include "assert_macros.svh"

module rgbfs_checker (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_valid,
    input logic                 s_ready,
    input rgbfs_pkg::in_beat_t  s_data,
    input logic                 m_valid,
    input logic                 m_ready,
    input rgbfs_pkg::out_beat_t m_data
);
    // a stalled result beat holds
    `ASSERT_CLK(a_m_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_data), "result beat changed while stalled")

    // last flag only on the final led
    `ASSERT_CLK(a_last_led, aclk, aresetn, m_valid |-> (m_data.last == (m_data.led_number == 5'(rgbfs_pkg::LAST_LED))), "last flag on wrong led")

    // a non-final beat is followed at once by the next led
    `ASSERT_CLK(a_next_led, aclk, aresetn, m_valid && m_ready && !m_data.last |=> m_valid && (m_data.led_number == $past(m_data.led_number) + 5'd1), "update beats not consecutive")

    // an accepted update command drops s_ready
    `ASSERT_CLK(a_upd_busy, aclk, aresetn, s_valid && s_ready && (s_data.func == rgbfs_pkg::FN_UPDATE) |=> !s_ready, "command taken during update")

    // reset empties the result register
    `ASSERT_ALWAYS(a_rst_empty, aclk, !aresetn |=> !m_valid, "result valid after reset")
endmodule

bind rgb_led_frame_store_scaler_top rgbfs_checker u_rgbfs_checker (.*);

// ===== tb/frame_store_checker.sv =====
`timescale 1ns / 100ps
// result checker for the rgb led frame store: tracks colours, brightness and white level
// from accepted beats and cfg writes, compares every result beat; depends on rgbfs_pkg
module frame_store_checker (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  rgbfs_pkg::in_beat_t  s_data,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  rgbfs_pkg::out_beat_t m_data,
    input  logic                 cfg_wr_en,
    input  logic [7:0]           cfg_wr_data,
    output int                   fail_count,
    output int                   beats_due
);
    localparam int LED_TOTAL  = 24;
    localparam int RED_SH     = 4;
    localparam int GREEN_SH   = 4;
    localparam int BLUE_SH    = 4;
    localparam int MAX_REPORT = 10;

    // fixed driver channel of each led
    localparam logic [6:0] RED_CH [LED_TOTAL] = '{
        7'd68, 7'd70, 7'd9,  7'd27, 7'd6,  7'd44, 7'd20, 7'd54, 7'd65, 7'd52, 7'd31, 7'd63,
        7'd28, 7'd13, 7'd49, 7'd40, 7'd38, 7'd18, 7'd12, 7'd2,  7'd32, 7'd35, 7'd43, 7'd41};
    localparam logic [6:0] GREEN_CH [LED_TOTAL] = '{
        7'd60, 7'd62, 7'd26, 7'd15, 7'd7,  7'd42, 7'd10, 7'd59, 7'd51, 7'd56, 7'd1,  7'd64,
        7'd34, 7'd53, 7'd47, 7'd61, 7'd45, 7'd22, 7'd23, 7'd30, 7'd25, 7'd67, 7'd29, 7'd21};
    localparam logic [6:0] BLUE_CH [LED_TOTAL] = '{
        7'd71, 7'd69, 7'd8,  7'd11, 7'd4,  7'd14, 7'd17, 7'd57, 7'd66, 7'd58, 7'd46, 7'd33,
        7'd3,  7'd50, 7'd55, 7'd36, 7'd48, 7'd37, 7'd16, 7'd5,  7'd24, 7'd39, 7'd0,  7'd19};

    logic [23:0]          colour_mem [LED_TOTAL];
    logic [7:0]           bright_mem [LED_TOTAL];
    logic [7:0]           white_level;
    rgbfs_pkg::out_beat_t led_beats_due [$];
    int                   reported;

    initial begin
        fail_count = 0;
        beats_due  = 0;
        reported   = 0;
    end

    function automatic logic [11:0] scaled_level(input logic [7:0] br, input logic [7:0] comp,
                                                 input int sh);
        logic [15:0] prod;
        prod = 16'(br) * 16'(comp);
        prod = prod >> sh;
        return (prod > 16'd4095) ? 12'hFFF : prod[11:0];
    endfunction

    function automatic string beat_text(input rgbfs_pkg::out_beat_t b);
        return $sformatf("led %0d r %0d/%0d g %0d/%0d b %0d/%0d white %0d last %0d",
                         b.led_number, b.red_channel, b.red_value, b.green_channel,
                         b.green_value, b.blue_channel, b.blue_value, b.white_out, b.last);
    endfunction

    task automatic apply_command(input rgbfs_pkg::in_beat_t c);
        rgbfs_pkg::out_beat_t b;
        int                   i;
        case (c.func)
            rgbfs_pkg::FN_SET_LED: begin
                if (c.led_index < LED_TOTAL) begin
                    colour_mem[c.led_index] = {c.red, c.green, c.blue};
                    if (c.override_brightness) bright_mem[c.led_index] = c.brightness;
                end
            end
            rgbfs_pkg::FN_SET_SINGLE: begin
                for (i = 0; i < LED_TOTAL; i++) colour_mem[i] = '0;
                if (c.led_index < LED_TOTAL) begin
                    colour_mem[c.led_index] = {c.red, c.green, c.blue};
                    if (c.override_brightness) bright_mem[c.led_index] = c.brightness;
                end
            end
            rgbfs_pkg::FN_FILL: begin
                for (i = 0; i < LED_TOTAL; i++) colour_mem[i] = {c.red, c.green, c.blue};
            end
            rgbfs_pkg::FN_SET_BRIGHT: begin
                for (i = 0; i < LED_TOTAL; i++) bright_mem[i] = c.brightness;
            end
            rgbfs_pkg::FN_UPDATE: begin
                for (i = 0; i < LED_TOTAL; i++) begin
                    b.led_number    = 5'(i);
                    b.red_channel   = RED_CH[i];
                    b.red_value     = scaled_level(bright_mem[i], colour_mem[i][23:16], RED_SH);
                    b.green_channel = GREEN_CH[i];
                    b.green_value   = scaled_level(bright_mem[i], colour_mem[i][15:8], GREEN_SH);
                    b.blue_channel  = BLUE_CH[i];
                    b.blue_value    = scaled_level(bright_mem[i], colour_mem[i][7:0], BLUE_SH);
                    b.white_out     = white_level;
                    b.last          = (i == LED_TOTAL - 1);
                    led_beats_due.push_back(b);
                end
            end
            default: ;  // spare codes do nothing
        endcase
    endtask

    task automatic log_fault(input string what, input rgbfs_pkg::out_beat_t want,
                             input rgbfs_pkg::out_beat_t got);
        fail_count++;
        if (reported < MAX_REPORT) begin
            reported++;
            $display("%0t %s", $realtime, what);
            $display("  expected %s", beat_text(want));
            $display("  actual   %s", beat_text(got));
        end
    endtask

    always @(posedge aclk) begin
        rgbfs_pkg::out_beat_t want;
        int                   i;
        if (!aresetn) begin
            for (i = 0; i < LED_TOTAL; i++) begin
                colour_mem[i] = '0;
                bright_mem[i] = '0;
            end
            white_level = '0;
            led_beats_due.delete();
        end else begin
            if (cfg_wr_en) white_level = cfg_wr_data;
            // result first: a command taken on the same edge cannot have produced it
            if (m_valid && m_ready) begin
                if (led_beats_due.size() == 0) begin
                    log_fault("result beat with nothing expected", '0, m_data);
                end else begin
                    want = led_beats_due.pop_front();
                    if (m_data.led_number    !== want.led_number    ||
                        m_data.red_channel   !== want.red_channel   ||
                        m_data.red_value     !== want.red_value     ||
                        m_data.green_channel !== want.green_channel ||
                        m_data.green_value   !== want.green_value   ||
                        m_data.blue_channel  !== want.blue_channel  ||
                        m_data.blue_value    !== want.blue_value    ||
                        m_data.white_out     !== want.white_out     ||
                        m_data.last          !== want.last) begin
                        log_fault("result beat mismatch", want, m_data);
                    end
                end
            end
            if (s_valid && s_ready) apply_command(s_data);
        end
        beats_due = led_beats_due.size();
    end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// top of the rgb led frame store testbench: clock, reset, command stimulus and result stalls
// depends on rgbfs_pkg, rgb_led_frame_store_scaler_top and frame_store_checker
module testbench;
    localparam int HALF_PERIOD      = 4;
    localparam int RESET_CYCLES     = 12;
    localparam int LED_TOTAL        = 24;
    // settle time after the last expected beat, long enough for a sweep in flight to finish
    localparam int SETTLE_CYCLES    = 40;
    localparam int HOLD_CYCLES      = 400;
    localparam int CYCLE_LIMIT      = 400000;
    localparam int RANDOM_PER_PHASE = 70;
    localparam int BURST_UPDATES    = 6;
    // codes the block has no use for
    localparam logic [2:0] FN_SPARE_LO = 3'd5;
    localparam logic [2:0] FN_SPARE_HI = 3'd7;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    rgbfs_pkg::in_beat_t  s_data;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    rgbfs_pkg::out_beat_t m_data;
    logic                 cfg_wr_en;
    logic [7:0]           cfg_wr_data;

    int fail_count;
    int beats_due;
    int send_idle_pct = 38;
    int recv_idle_pct = 84;
    int holds_asked   = 0;
    int holds_served  = 0;
    int hold_left     = 0;
    int cycle_count   = 0;

    // 8 ns clock
    always begin
        #HALF_PERIOD aclk = 1'b1;
        #HALF_PERIOD aclk = 1'b0;
    end

    rgb_led_frame_store_scaler_top u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    frame_store_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .fail_count  (fail_count),
        .beats_due   (beats_due)
    );

    // watchdog on the whole run
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // result side: random stalls, or a long hold-off when one is asked for
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (holds_asked != holds_served) begin
            holds_served <= holds_served + 1;
            hold_left    <= HOLD_CYCLES;
            m_ready      <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    function automatic rgbfs_pkg::in_beat_t make_cmd(input logic [2:0] f,
                                                     input logic [7:0] idx,
                                                     input logic [23:0] rgb, input logic ovr,
                                                     input logic [7:0] br);
        rgbfs_pkg::in_beat_t c;
        c.func                = f;
        c.led_index           = idx;
        c.red                 = rgb[23:16];
        c.green               = rgb[15:8];
        c.blue                = rgb[7:0];
        c.override_brightness = ovr;
        c.brightness          = br;
        return c;
    endfunction

    // component or brightness, leaning on the extremes now and then
    function automatic logic [7:0] random_level();
        int pick;
        pick = $urandom_range(0, 15);
        if (pick == 0) return 8'h00;
        if (pick == 1) return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic rgbfs_pkg::in_beat_t random_cmd();
        rgbfs_pkg::in_beat_t c;
        int                  pick;
        pick = $urandom_range(0, 99);
        // mostly valid led numbers, some anywhere in the 8-bit range
        if ($urandom_range(0, 4) == 0) c.led_index = 8'($urandom_range(0, 255));
        else c.led_index = 8'($urandom_range(0, LED_TOTAL - 1));
        c.red                 = random_level();
        c.green               = random_level();
        c.blue                = random_level();
        c.override_brightness = 1'($urandom_range(0, 1));
        c.brightness          = random_level();
        if (pick < 45) c.func = rgbfs_pkg::FN_SET_LED;
        else if (pick < 55) c.func = rgbfs_pkg::FN_SET_SINGLE;
        else if (pick < 62) c.func = rgbfs_pkg::FN_FILL;
        else if (pick < 72) c.func = rgbfs_pkg::FN_SET_BRIGHT;
        else if (pick < 96) c.func = rgbfs_pkg::FN_UPDATE;
        else c.func = 3'($urandom_range(FN_SPARE_LO, FN_SPARE_HI));
        return c;
    endfunction

    // present one command beat and hold it until taken; entered and left at a falling edge
    task automatic send_cmd(input rgbfs_pkg::in_beat_t c);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= c;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // random commands until n of them did something
    task automatic run_random(input int n);
        rgbfs_pkg::in_beat_t c;
        int                  done;
        done = 0;
        while (done < n) begin
            c = random_cmd();
            send_cmd(c);
            if (!(c.func >= FN_SPARE_LO ||
                  (c.func == rgbfs_pkg::FN_SET_LED && c.led_index >= LED_TOTAL))) done++;
        end
    endtask

    // let every expected beat come out, then let any sweep still running finish
    task automatic drain_and_settle();
        s_valid <= 1'b0;
        while (beats_due != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_white(input logic [7:0] level);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= level;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    initial begin
        int i;
        s_valid     = 1'b0;
        s_data      = '0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        aresetn     = 1'b0;
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed part, white at its top value
        write_white(8'hFF);
        // frame straight out of reset is all black
        send_cmd(make_cmd(rgbfs_pkg::FN_UPDATE, 8'd0, 24'h000000, 1'b0, 8'h00));
        // full brightness and full white colour give the largest levels
        send_cmd(make_cmd(rgbfs_pkg::FN_SET_BRIGHT, 8'd0, 24'h000000, 1'b0, 8'hFF));
        send_cmd(make_cmd(rgbfs_pkg::FN_FILL, 8'd0, 24'hFFFFFF, 1'b0, 8'h00));
        send_cmd(make_cmd(rgbfs_pkg::FN_UPDATE, 8'd0, 24'h000000, 1'b0, 8'h00));
        // first and last led, with and without brightness override
        send_cmd(make_cmd(rgbfs_pkg::FN_SET_LED, 8'd0, 24'hFF0000, 1'b1, 8'h00));
        send_cmd(make_cmd(rgbfs_pkg::FN_SET_LED, 8'd23, 24'h00FFAA, 1'b0, 8'h11));
        // out-of-range set led is dropped
        send_cmd(make_cmd(rgbfs_pkg::FN_SET_LED, 8'd24, 24'h123456, 1'b1, 8'h01));
        send_cmd(make_cmd(rgbfs_pkg::FN_SET_LED, 8'd255, 24'hFFFFFF, 1'b1, 8'hFF));
        send_cmd(make_cmd(rgbfs_pkg::FN_UPDATE, 8'd0, 24'h000000, 1'b0, 8'h00));
        // single led blanks the others
        send_cmd(make_cmd(rgbfs_pkg::FN_SET_SINGLE, 8'd5, 24'h55AA0F, 1'b1, 8'h80));
        send_cmd(make_cmd(rgbfs_pkg::FN_UPDATE, 8'd0, 24'h000000, 1'b0, 8'h00));
        // single led out of range: everything goes black, brightness untouched
        send_cmd(make_cmd(rgbfs_pkg::FN_SET_SINGLE, 8'd200, 24'hFFFFFF, 1'b1, 8'h03));
        send_cmd(make_cmd(rgbfs_pkg::FN_UPDATE, 8'd0, 24'h000000, 1'b0, 8'h00));
        // spare codes give nothing
        for (i = FN_SPARE_LO; i <= FN_SPARE_HI; i++) begin
            send_cmd(make_cmd(3'(i), 8'($urandom_range(0, 255)), 24'($urandom),
                              1'b1, 8'($urandom_range(0, 255))));
        end
        // fill ignores the override bit
        send_cmd(make_cmd(rgbfs_pkg::FN_FILL, 8'd3, 24'h010203, 1'b1, 8'h07));
        send_cmd(make_cmd(rgbfs_pkg::FN_SET_LED, 8'd12, 24'hFEDCBA, 1'b1, 8'hC3));
        send_cmd(make_cmd(rgbfs_pkg::FN_UPDATE, 8'd0, 24'h000000, 1'b0, 8'h00));
        drain_and_settle();

        // phase one: sender idles less than the receiver
        write_white(8'h00);
        run_random(RANDOM_PER_PHASE);
        drain_and_settle();

        // phase two: the other way round
        write_white(8'($urandom_range(1, 254)));
        send_idle_pct = 84;
        recv_idle_pct = 38;
        run_random(RANDOM_PER_PHASE);
        drain_and_settle();

        // phase three: no idling, opening with a long receiver hold-off
        // while updates keep coming so the input side backs up
        write_white(8'h5A);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        holds_asked <= holds_asked + 1;
        for (i = 0; i < BURST_UPDATES; i++) begin
            send_cmd(make_cmd(rgbfs_pkg::FN_UPDATE, 8'($urandom_range(0, 255)), 24'($urandom),
                              1'($urandom_range(0, 1)), 8'($urandom_range(0, 255))));
        end
        run_random(RANDOM_PER_PHASE);
        drain_and_settle();

        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/rgbfs_pkg.sv
rtl/rgbfs_ram.sv
rtl/rgbfs_ctrl.sv
rtl/rgbfs_dp.sv
rtl/rgb_led_frame_store_scaler_top.sv
rtl/rgbfs_checker.sv
tb/frame_store_checker.sv
tb/testbench.sv
